FILE: hw/rtl/ray_segment_intersect_2d_defines.svh
// ----------------------------------------------------------------------------
// ray_segment_intersect_2d_defines
// assertion macros shared by the ray/segment intersection rtl
// ----------------------------------------------------------------------------
`ifndef RAY_SEGMENT_INTERSECT_2D_DEFINES_SVH
`define RAY_SEGMENT_INTERSECT_2D_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RSI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsi assertion failed");
// next-cycle implication
`define RSI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsi assertion failed");
`else
`define RSI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RSI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// shared widths, constants and types of the ray/segment intersection block
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int CW = 32;   // coordinate width, Q16.16
    localparam int DW = 33;   // coordinate difference width
    localparam int NW = 16;   // normal width, Q1.15
    localparam int RW = 52;   // plane distance width, Q.31
    localparam int QW = 16;   // quotient bits
    localparam int FW = 17;   // fraction width, Q0.16 plus the one

    localparam logic [15:0]   EPS_RESET = 16'd6554;
    localparam logic [0:0]    REG_PULLBACK_EPS = 1'b0;
    localparam logic [FW-1:0] FRAC_ONE = 17'h10000;

    typedef struct packed {
        logic                 hit;
        logic                 zero;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
    } rsi_side_t;

endpackage

FILE: hw/rtl/rsi_div.sv
// ----------------------------------------------------------------------------
// rsi_div
// pipelined restoring divider, saturation check then one quotient bit per stage, with side data
// ----------------------------------------------------------------------------
module rsi_div
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     valid,
    input  logic [rsi_pkg::RW-1:0]   n,
    input  logic [rsi_pkg::RW-1:0]   d,
    input  rsi_pkg::rsi_side_t       side,
    output logic                     q_valid,
    output logic [rsi_pkg::QW-1:0]   q,
    output logic                     sat,
    output rsi_pkg::rsi_side_t       q_side
);

    localparam int NS = rsi_pkg::QW + 1;

    logic [rsi_pkg::RW-1:0] n_reg    [0:NS-1];
    logic [rsi_pkg::RW-1:0] d_reg    [0:NS-1];
    logic [rsi_pkg::QW-1:0] q_reg    [0:NS-1];
    logic                   sat_reg  [0:NS-1];
    rsi_pkg::rsi_side_t     side_reg [0:NS-1];
    logic                   v_reg    [0:NS-1];

    logic [rsi_pkg::RW-1:0] n_next   [1:NS-1];
    logic [rsi_pkg::QW-1:0] q_next   [1:NS-1];

    always_comb
    begin
        for (int k = 1; k < NS; k++)
        begin
            logic [rsi_pkg::RW-1:0] sh;
            sh = {n_reg[k-1][rsi_pkg::RW-2:0], 1'b0};
            if (sh >= d_reg[k-1])
            begin
                n_next[k] = sh - d_reg[k-1];
                q_next[k] = {q_reg[k-1][rsi_pkg::QW-2:0], 1'b1};
            end
            else
            begin
                n_next[k] = sh;
                q_next[k] = {q_reg[k-1][rsi_pkg::QW-2:0], 1'b0};
            end
        end
    end

    // stage 0: saturation check, quotient starts empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]    <= n;
            d_reg[0]    <= d;
            q_reg[0]    <= '0;
            sat_reg[0]  <= (n >= d);
            side_reg[0] <= side;
        end
    end

    for (genvar k = 1; k < NS; k++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]    <= n_next[k];
                d_reg[k]    <= d_reg[k-1];
                q_reg[k]    <= q_next[k];
                sat_reg[k]  <= sat_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign q_valid = v_reg[NS-1];
    assign q       = q_reg[NS-1];
    assign sat     = sat_reg[NS-1];
    assign q_side  = side_reg[NS-1];

endmodule

FILE: hw/rtl/ray_segment_intersect_2d.sv
// ----------------------------------------------------------------------------
// ray_segment_intersect_2d
// 2-d ray against wall segment test with pulled-back hit fraction
// ----------------------------------------------------------------------------
// items come in on the item channel (item_valid/item_stall), one ray and one
// wall per transfer; each item gives exactly one result transfer on the
// result channel (result_valid/result_stall), in order.
// throughput: one item per cycle while no waiting result is held by result_stall;
// under that condition the 17-stage divider takes a new pair every cycle, a
// saturation check followed by one quotient bit per stage.
// when result_stall holds a waiting result the whole pipeline freezes and
// item_stall rises in the same cycle; nothing is lost or repeated.
// reset clears all valid bits and sets pullback_epsilon to 6554.
// pullback_epsilon is written over the apb port at byte address 0; the user
// must write it only while no items are in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
`include "ray_segment_intersect_2d_defines.svh"

module ray_segment_intersect_2d
(
    input  logic                            clk,
    input  logic                            rst_n,
    // apb
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // items
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic signed [rsi_pkg::CW-1:0]   ray_start_x,
    input  logic signed [rsi_pkg::CW-1:0]   ray_start_y,
    input  logic signed [rsi_pkg::CW-1:0]   ray_end_x,
    input  logic signed [rsi_pkg::CW-1:0]   ray_end_y,
    input  logic signed [rsi_pkg::CW-1:0]   wall_start_x,
    input  logic signed [rsi_pkg::CW-1:0]   wall_start_y,
    input  logic signed [rsi_pkg::CW-1:0]   wall_end_x,
    input  logic signed [rsi_pkg::CW-1:0]   wall_end_y,
    input  logic signed [rsi_pkg::NW-1:0]   wall_normal_x,
    input  logic signed [rsi_pkg::NW-1:0]   wall_normal_y,
    input  logic signed [rsi_pkg::CW-1:0]   wall_offset,
    // results
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic                            hit,
    output logic signed [rsi_pkg::CW-1:0]   cross_x,
    output logic signed [rsi_pkg::CW-1:0]   cross_y,
    output logic [rsi_pkg::FW-1:0]          fraction
);

    localparam int CW = rsi_pkg::CW;
    localparam int DW = rsi_pkg::DW;
    localparam int NW = rsi_pkg::NW;
    localparam int RW = rsi_pkg::RW;
    localparam int FW = rsi_pkg::FW;
    localparam int FACE_W = DW + NW + 1;
    localparam int PW = 2 * DW;
    localparam int MW = CW + NW;
    localparam int LW = DW + FW + 1;
    localparam int SW = RW;

    logic en;
    logic [15:0] eps_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= rsi_pkg::EPS_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == rsi_pkg::REG_PULLBACK_EPS)
        begin
            eps_reg <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rsi_pkg::REG_PULLBACK_EPS) ? {16'b0, eps_reg} : 32'b0;

    assign en         = !(result_valid && result_stall);
    assign item_stall = !en;

    // stage 1: differences
    logic                 v1_reg;
    logic signed [DW-1:0] dx1_reg, dy1_reg, ax1_reg, ay1_reg, bx1_reg, by1_reg;
    logic signed [CW-1:0] sx1_reg, sy1_reg, ex1_reg, ey1_reg, off1_reg;
    logic signed [NW-1:0] nx1_reg, ny1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg  <= DW'(ray_end_x) - DW'(ray_start_x);
            dy1_reg  <= DW'(ray_end_y) - DW'(ray_start_y);
            ax1_reg  <= DW'(wall_start_x) - DW'(ray_start_x);
            ay1_reg  <= DW'(wall_start_y) - DW'(ray_start_y);
            bx1_reg  <= DW'(wall_end_x) - DW'(ray_start_x);
            by1_reg  <= DW'(wall_end_y) - DW'(ray_start_y);
            sx1_reg  <= ray_start_x;
            sy1_reg  <= ray_start_y;
            ex1_reg  <= ray_end_x;
            ey1_reg  <= ray_end_y;
            off1_reg <= wall_offset;
            nx1_reg  <= wall_normal_x;
            ny1_reg  <= wall_normal_y;
        end
    end

    // stage 2: products
    logic                     v2_reg;
    logic signed [FACE_W-1:0] face2_reg;
    logic signed [PW-1:0]     p1_2_reg, q1_2_reg, p2_2_reg, q2_2_reg;
    logic signed [MW-1:0]     msx2_reg, msy2_reg, mex2_reg, mey2_reg;
    logic signed [DW-1:0]     dx2_reg, dy2_reg;
    logic signed [CW-1:0]     sx2_reg, sy2_reg, off2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            face2_reg <= dx1_reg * nx1_reg + dy1_reg * ny1_reg;
            p1_2_reg  <= ax1_reg * dy1_reg;
            q1_2_reg  <= ay1_reg * dx1_reg;
            p2_2_reg  <= bx1_reg * dy1_reg;
            q2_2_reg  <= by1_reg * dx1_reg;
            msx2_reg  <= sx1_reg * nx1_reg;
            msy2_reg  <= sy1_reg * ny1_reg;
            mex2_reg  <= ex1_reg * nx1_reg;
            mey2_reg  <= ey1_reg * ny1_reg;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            sx2_reg   <= sx1_reg;
            sy2_reg   <= sy1_reg;
            off2_reg  <= off1_reg;
        end
    end

    // stage 3: side tests and plane distances
    logic signed [PW:0]   dw1_next, dw2_next;
    logic signed [RW-1:0] off15_next;
    logic                 v3_reg, face_ok3_reg, wall_ok3_reg;
    logic signed [RW-1:0] rs3_reg, re3_reg;
    logic signed [DW-1:0] dx3_reg, dy3_reg;
    logic signed [CW-1:0] sx3_reg, sy3_reg;

    always_comb
    begin
        dw1_next   = (PW+1)'(p1_2_reg) - (PW+1)'(q1_2_reg);
        dw2_next   = (PW+1)'(p2_2_reg) - (PW+1)'(q2_2_reg);
        off15_next = $signed({{(RW-CW-15){off2_reg[CW-1]}}, off2_reg, 15'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            face_ok3_reg <= face2_reg[FACE_W-1];
            wall_ok3_reg <= (dw1_next != '0) && (dw2_next != '0)
                            && (dw1_next[PW] != dw2_next[PW]);
            rs3_reg      <= RW'(msx2_reg) + RW'(msy2_reg) - off15_next;
            re3_reg      <= RW'(mex2_reg) + RW'(mey2_reg) - off15_next;
            dx3_reg      <= dx2_reg;
            dy3_reg      <= dy2_reg;
            sx3_reg      <= sx2_reg;
            sy3_reg      <= sy2_reg;
        end
    end

    // stage 4: hit decision, pulled-back numerator and denominator
    logic signed [RW-1:0] eps15_next;
    logic                 v4_reg, hit4_reg;
    logic signed [RW-1:0] num4_reg, den4_reg;
    logic signed [DW-1:0] dx4_reg, dy4_reg;
    logic signed [CW-1:0] sx4_reg, sy4_reg;

    assign eps15_next = $signed({{(RW-31){1'b0}}, eps_reg, 15'b0});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit4_reg <= face_ok3_reg && wall_ok3_reg && (rs3_reg != '0) && (re3_reg != '0)
                        && (rs3_reg[RW-1] != re3_reg[RW-1]);
            num4_reg <= rs3_reg[RW-1] ? rs3_reg + eps15_next : rs3_reg - eps15_next;
            den4_reg <= rs3_reg - re3_reg;
            dx4_reg  <= dx3_reg;
            dy4_reg  <= dy3_reg;
            sx4_reg  <= sx3_reg;
            sy4_reg  <= sy3_reg;
        end
    end

    // stage 5: magnitudes
    logic               v5_reg;
    logic [RW-1:0]      n5_reg, d5_reg;
    rsi_pkg::rsi_side_t side5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n5_reg          <= num4_reg[RW-1] ? RW'(-num4_reg) : RW'(num4_reg);
            d5_reg          <= den4_reg[RW-1] ? RW'(-den4_reg) : RW'(den4_reg);
            side5_reg.hit   <= hit4_reg;
            side5_reg.zero  <= (num4_reg == '0) || (num4_reg[RW-1] != den4_reg[RW-1]);
            side5_reg.dx    <= dx4_reg;
            side5_reg.dy    <= dy4_reg;
            side5_reg.sx    <= sx4_reg;
            side5_reg.sy    <= sy4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= item_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // divider
    logic                         vq;
    logic [rsi_pkg::QW-1:0]       q_div;
    logic                         sat_div;
    rsi_pkg::rsi_side_t           side_div;

    rsi_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid   (v5_reg),
        .n       (n5_reg),
        .d       (d5_reg),
        .side    (side5_reg),
        .q_valid (vq),
        .q       (q_div),
        .sat     (sat_div),
        .q_side  (side_div)
    );

    // interpolation products
    logic [FW-1:0]        f_next;
    logic                 vl_reg, hitl_reg;
    logic [FW-1:0]        fl_reg;
    logic signed [LW-1:0] px_reg, py_reg;
    logic signed [CW-1:0] sxl_reg, syl_reg;

    always_comb
    begin
        if (!side_div.hit || side_div.zero)
        begin
            f_next = '0;
        end
        else if (sat_div)
        begin
            f_next = rsi_pkg::FRAC_ONE;
        end
        else
        begin
            f_next = {1'b0, q_div};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hitl_reg <= side_div.hit;
            fl_reg   <= f_next;
            px_reg   <= side_div.dx * $signed({1'b0, f_next});
            py_reg   <= side_div.dy * $signed({1'b0, f_next});
            sxl_reg  <= side_div.sx;
            syl_reg  <= side_div.sy;
        end
    end

    // output register: start + delta * f, rounded half up
    logic signed [SW-1:0] sumx_next, sumy_next;
    logic                 result_valid_reg, hit_reg;
    logic signed [CW-1:0] cross_x_reg, cross_y_reg;
    logic [FW-1:0]        fraction_reg;

    always_comb
    begin
        sumx_next = $signed({{(SW-CW-16){sxl_reg[CW-1]}}, sxl_reg, 16'b0})
                    + SW'(px_reg) + SW'(32768);
        sumy_next = $signed({{(SW-CW-16){syl_reg[CW-1]}}, syl_reg, 16'b0})
                    + SW'(py_reg) + SW'(32768);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vl_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vl_reg           <= vq;
            result_valid_reg <= vl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg      <= hitl_reg;
            cross_x_reg  <= hitl_reg ? sumx_next[CW+15:16] : '0;
            cross_y_reg  <= hitl_reg ? sumy_next[CW+15:16] : '0;
            fraction_reg <= fl_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign hit          = hit_reg;
    assign cross_x      = cross_x_reg;
    assign cross_y      = cross_y_reg;
    assign fraction     = fraction_reg;

    `RSI_ASSERT_IMP(a_miss_zero, clk, rst_n, result_valid && !hit, cross_x == 0 && cross_y == 0 && fraction == 0)
    `RSI_ASSERT_IMP(a_frac_range, clk, rst_n, result_valid, fraction <= rsi_pkg::FRAC_ONE)
    `RSI_ASSERT_NXT(a_freeze, clk, rst_n, result_valid && result_stall, $stable(vl_reg) && $stable(vq))

endmodule
